@@ hw/rtl/lcdseq_pkg.sv @@
`default_nettype none

package lcdseq_pkg;

    // Request codes on the func field
    typedef enum logic [2:0] {
        FUNC_INIT   = 3'd0,
        FUNC_CMD    = 3'd1,
        FUNC_DATA   = 3'd2,
        FUNC_CURSOR = 3'd3,
        FUNC_DIGIT  = 3'd4,
        FUNC_NUMBER = 3'd5
    } func_t;

    // Configuration register indexes
    localparam logic CFG_FOUR_BIT_BUS = 1'b0;
    localparam logic CFG_STROBE_HIGH  = 1'b1;

    localparam logic [7:0] STROBE_HIGH_RESET = 8'd10;
    localparam logic [4:0] WAIT_BEFORE_LONG  = 5'd20;
    localparam logic [4:0] WAIT_BEFORE_NONE  = 5'd0;
    localparam logic [9:0] WAIT_AFTER_LONG   = 10'd1001;
    localparam logic [9:0] WAIT_AFTER_SHORT  = 10'd1;
    localparam logic [7:0] ASCII_ZERO        = 8'd48;
    localparam logic [6:0] NUMBER_MAX        = 7'd99;

    localparam int PC_W = 4;

    typedef enum logic {
        OP_EMIT,        // send one byte, then go to next_pc or finish
        OP_SKIP_EIGHT   // in 8-bit mode jump to next_pc, else fall through
    } uop_t;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_VALUE,
        SRC_CURSOR,
        SRC_DIGIT,
        SRC_TENS,
        SRC_ONES
    } byte_src_t;

    typedef struct packed {
        uop_t             op;
        byte_src_t        src;
        logic [7:0]       const_byte;
        logic             rs;
        logic             wb_long;
        logic             wa_long;
        logic             end_req;
        logic [PC_W-1:0]  next_pc;
    } uword_t;

    // Control from sequencer to datapath for one strobe
    typedef struct packed {
        logic       load;
        byte_src_t  src;
        logic [7:0] const_byte;
        logic       rs;
        logic       wb_long;
        logic       wa_long;
        logic       four;
        logic       lo_nibble;
        logic       final_strobe;
    } strobe_ctl_t;

    // Entry points of each request
    localparam logic [PC_W-1:0] PC_INIT   = 4'd0;
    localparam logic [PC_W-1:0] PC_CMD    = 4'd8;
    localparam logic [PC_W-1:0] PC_DATA   = 4'd9;
    localparam logic [PC_W-1:0] PC_CURSOR = 4'd10;
    localparam logic [PC_W-1:0] PC_DIGIT  = 4'd11;
    localparam logic [PC_W-1:0] PC_NUMBER = 4'd12;

    function automatic uword_t emit_word(input byte_src_t src, input logic [7:0] cb,
                                         input logic rs, input logic wb, input logic wa,
                                         input logic fin, input logic [PC_W-1:0] nxt);
        uword_t w;
        w.op         = OP_EMIT;
        w.src        = src;
        w.const_byte = cb;
        w.rs         = rs;
        w.wb_long    = wb;
        w.wa_long    = wa;
        w.end_req    = fin;
        w.next_pc    = nxt;
        return w;
    endfunction

    // Microprogram
    function automatic uword_t ucode_word(input logic [PC_W-1:0] pc);
        uword_t w;
        w = emit_word(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0);
        case (pc)
            4'd0:
            begin
                w.op      = OP_SKIP_EIGHT;
                w.end_req = 1'b0;
                w.next_pc = 4'd4;
            end
            4'd1:  w = emit_word(SRC_CONST, 8'h33, 1'b0, 1'b0, 1'b0, 1'b0, 4'd2);
            4'd2:  w = emit_word(SRC_CONST, 8'h32, 1'b0, 1'b0, 1'b0, 1'b0, 4'd3);
            4'd3:  w = emit_word(SRC_CONST, 8'h28, 1'b0, 1'b0, 1'b0, 1'b0, 4'd5);
            4'd4:  w = emit_word(SRC_CONST, 8'h38, 1'b0, 1'b1, 1'b0, 1'b0, 4'd5);
            4'd5:  w = emit_word(SRC_CONST, 8'h0e, 1'b0, 1'b0, 1'b0, 1'b0, 4'd6);
            4'd6:  w = emit_word(SRC_CONST, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 4'd7);
            4'd7:  w = emit_word(SRC_CONST, 8'h06, 1'b0, 1'b1, 1'b0, 1'b1, 4'd0);
            4'd8:  w = emit_word(SRC_VALUE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0);
            4'd9:  w = emit_word(SRC_VALUE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0);
            4'd10: w = emit_word(SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0);
            4'd11: w = emit_word(SRC_DIGIT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0);
            4'd12: w = emit_word(SRC_TENS, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 4'd13);
            4'd13: w = emit_word(SRC_ONES, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0);
            default: w = emit_word(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0);
        endcase
        return w;
    endfunction

    function automatic logic [7:0] line_base(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h94;
            default: b = 8'hD4;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/char_lcd_bus_sequencer_top.sv @@
`default_nettype none
// Character LCD bus sequencer.
// Input channel (in_valid/in_stall): one request per transfer: func selects
// init, command, data, cursor move, digit or two-digit number; value, row
// and column carry its operands. Output channel (out_valid/out_stall): one
// enable strobe per transfer with register select, data port byte, waits in
// tenths of a millisecond, and last set on the request's final strobe.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 = four_bit_bus,
// index 1 = strobe_high_tenths. Write only while the block is idle.
// The request transfer loads the step counter; the first strobe then goes
// into the output register, for init after the bus-mode branch step.
// Throughput: one strobe per cycle from the microcode step counter while the
// output is not stalled, apart from the bus-mode branch step of init; the
// sequencer works on one request at a time.
// in_stall is high while a request is in progress. A stalled receiver holds
// the output register and freezes the step counter; nothing is lost.
// Unknown func codes are taken and produce no strobes.
// Reset: idle, empty output, 8-bit bus mode, strobe high time 10.

module char_lcd_bus_sequencer_top
    import lcdseq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] func,
    input  wire logic [7:0] value,
    input  wire logic [2:0] row,
    input  wire logic [4:0] column,
    // strobe channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            reg_select,
    output logic [7:0]      port_byte,
    output logic [4:0]      wait_before,
    output logic [7:0]      strobe_high,
    output logic [9:0]      wait_after,
    output logic            last,
    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic        four_reg;
    logic [7:0]  strobe_cfg_reg;
    logic [7:0]  value_reg;
    logic [2:0]  row_reg;
    logic [4:0]  column_reg;

    logic        busy;
    logic        in_xfer;
    logic        out_free;
    strobe_ctl_t ctl;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign in_xfer   = in_valid && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_reg       <= 1'b0;
            strobe_cfg_reg <= STROBE_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FOUR_BIT_BUS)
            begin
                four_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_STROBE_HIGH)
            begin
                strobe_cfg_reg <= cfg_data;
            end
        end
    end

    // Request operands, held for the whole request
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            value_reg  <= value;
            row_reg    <= row;
            column_reg <= column;
        end
    end

    // Step counter and microcode ROM
    lcdseq_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_xfer),
        .func         (func),
        .four_bit_bus (four_reg),
        .out_free     (out_free),
        .busy         (busy),
        .ctl          (ctl)
    );

    // Byte select, nibble split, wait fields and output register
    lcdseq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .value       (value_reg),
        .row         (row_reg),
        .column      (column_reg),
        .strobe_cfg  (strobe_cfg_reg),
        .out_stall   (out_stall),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .reg_select  (reg_select),
        .port_byte   (port_byte),
        .wait_before (wait_before),
        .strobe_high (strobe_high),
        .wait_after  (wait_after),
        .last        (last)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lcdseq_sequencer.sv @@
`default_nettype none

module lcdseq_sequencer
    import lcdseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  func,
    input  wire logic        four_bit_bus,
    input  wire logic        out_free,
    output logic             busy,
    output strobe_ctl_t      ctl
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            nib_reg, nib_next;
    logic            entry_ok;
    logic [PC_W-1:0] entry_pc;
    uword_t          word;
    logic            fire;
    logic            byte_done;

    always_comb
    begin
        entry_ok = 1'b1;
        entry_pc = PC_INIT;
        unique case (func)
            FUNC_INIT:   entry_pc = PC_INIT;
            FUNC_CMD:    entry_pc = PC_CMD;
            FUNC_DATA:   entry_pc = PC_DATA;
            FUNC_CURSOR: entry_pc = PC_CURSOR;
            FUNC_DIGIT:  entry_pc = PC_DIGIT;
            FUNC_NUMBER: entry_pc = PC_NUMBER;
            default:     entry_ok = 1'b0;   // unknown request: dropped
        endcase
    end

    assign word      = ucode_word(pc_reg);
    assign fire      = busy_reg && (word.op == OP_EMIT) && out_free;
    assign byte_done = !four_bit_bus || nib_reg;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        nib_next  = nib_reg;
        if (!busy_reg)
        begin
            if (start && entry_ok)
            begin
                busy_next = 1'b1;
                pc_next   = entry_pc;
                nib_next  = 1'b0;
            end
        end
        else if (word.op == OP_SKIP_EIGHT)
        begin
            pc_next = four_bit_bus ? pc_reg + PC_W'(1) : word.next_pc;
        end
        else if (fire)
        begin
            if (!byte_done)
            begin
                nib_next = 1'b1;
            end
            else
            begin
                nib_next = 1'b0;
                pc_next  = word.next_pc;
                if (word.end_req)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
            nib_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            nib_reg  <= nib_next;
        end
    end

    always_comb
    begin
        ctl.load         = fire;
        ctl.src          = word.src;
        ctl.const_byte   = word.const_byte;
        ctl.rs           = word.rs;
        ctl.wb_long      = word.wb_long;
        ctl.wa_long      = word.wa_long;
        ctl.four         = four_bit_bus;
        ctl.lo_nibble    = nib_reg;
        ctl.final_strobe = word.end_req && byte_done;
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lcdseq_datapath.sv @@
`default_nettype none

module lcdseq_datapath
    import lcdseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire strobe_ctl_t ctl,
    input  wire logic [7:0]  value,
    input  wire logic [2:0]  row,
    input  wire logic [4:0]  column,
    input  wire logic [7:0]  strobe_cfg,
    input  wire logic        out_stall,
    output logic             out_free,
    output logic             out_valid,
    output logic             reg_select,
    output logic [7:0]       port_byte,
    output logic [4:0]       wait_before,
    output logic [7:0]       strobe_high,
    output logic [9:0]       wait_after,
    output logic             last
);

    logic        valid_reg, valid_next;
    logic        rs_reg;
    logic [7:0]  byte_reg;
    logic [4:0]  wb_reg;
    logic [7:0]  hi_reg;
    logic [9:0]  wa_reg;
    logic        last_reg;

    logic [6:0]  sat;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [2:0]  row_m1;
    logic [7:0]  cursor;
    logic [7:0]  full_byte;
    logic [7:0]  bus_byte;

    // tens = sat / 10 via reciprocal, exact for sat <= 99
    assign sat    = (value > {1'b0, NUMBER_MAX}) ? NUMBER_MAX : value[6:0];
    assign prod   = {8'd0, sat} * 15'd205;
    assign tens   = prod[14:11];
    assign ones   = 4'(sat - {3'd0, tens} * 7'd10);
    assign row_m1 = row - 3'd1;
    assign cursor = line_base(row_m1[1:0]) + {3'd0, column} - 8'd1;

    always_comb
    begin
        case (ctl.src)
            SRC_CONST:  full_byte = ctl.const_byte;
            SRC_VALUE:  full_byte = value;
            SRC_CURSOR: full_byte = cursor;
            SRC_DIGIT:  full_byte = value + ASCII_ZERO;
            SRC_TENS:   full_byte = {4'd0, tens} + ASCII_ZERO;
            SRC_ONES:   full_byte = {4'd0, ones} + ASCII_ZERO;
            default:    full_byte = ctl.const_byte;
        endcase
        if (!ctl.four)
        begin
            bus_byte = full_byte;
        end
        else if (ctl.lo_nibble)
        begin
            bus_byte = {full_byte[3:0], 4'd0};
        end
        else
        begin
            bus_byte = {full_byte[7:4], 4'd0};
        end
    end

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rs_reg   <= ctl.rs;
            byte_reg <= bus_byte;
            wb_reg   <= (ctl.wb_long && !ctl.lo_nibble) ? WAIT_BEFORE_LONG : WAIT_BEFORE_NONE;
            hi_reg   <= (strobe_cfg == 8'd0) ? 8'd1 : strobe_cfg;
            wa_reg   <= (ctl.wa_long && (!ctl.four || ctl.lo_nibble)) ?
                        WAIT_AFTER_LONG : WAIT_AFTER_SHORT;
            last_reg <= ctl.final_strobe;
        end
    end

    assign out_valid   = valid_reg;
    assign reg_select  = rs_reg;
    assign port_byte   = byte_reg;
    assign wait_before = wb_reg;
    assign strobe_high = hi_reg;
    assign wait_after  = wa_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

// Self-checking bench for the character LCD bus sequencer.
// Requests go in through a queue-fed driver, strobes come back through a
// monitor that compares them with the strobes predicted at request accept.
module tb_top;
    import lcdseq_pkg::*;

    // Unused request codes: the block must take them and emit nothing
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    // DDRAM start address of each display line, line 1 in the low byte
    localparam logic [31:0] LINE_STARTS = {8'hD4, 8'h94, 8'hC0, 8'h80};

    localparam logic [4:0] PRE_LONG   = 5'd20;
    localparam logic [4:0] PRE_NONE   = 5'd0;
    localparam logic [9:0] POST_SHORT = 10'd1;
    localparam logic [9:0] POST_HOME  = 10'd1001;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    // Quiet cycles before a register write; covers an ignored request that is
    // still being retired after the last strobe has come out.
    localparam int SETTLE_CYCLES = 16;
    // Cycles with no transfer on any channel before the run is declared hung
    localparam int HANG_LIMIT = 1000;

    typedef struct packed {
        logic [2:0] code;
        logic [7:0] arg;
        logic [2:0] line_no;
        logic [4:0] col_no;
    } request_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] port_val;
        logic [4:0] pre;
        logic [7:0] pulse;
        logic [9:0] post;
        logic       fin;
    } strobe_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] func = 3'd0;
    logic [7:0] value = 8'd0;
    logic [2:0] row = 3'd1;
    logic [4:0] column = 5'd1;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       reg_select;
    logic [7:0] port_byte;
    logic [4:0] wait_before;
    logic [7:0] strobe_high;
    logic [9:0] wait_after;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data = 8'd0;

    char_lcd_bus_sequencer_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .value       (value),
        .row         (row),
        .column      (column),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reg_select  (reg_select),
        .port_byte   (port_byte),
        .wait_before (wait_before),
        .strobe_high (strobe_high),
        .wait_after  (wait_after),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    request_t    pending_requests[$];
    strobe_t     expected_strobes[$];

    // Bench copy of the sequencer's registers and request history
    logic        bus_is_four = 1'b0;
    logic [7:0]  pulse_tenths = 8'd10;
    logic [2:0]  last_req_code = 3'd0;
    int unsigned last_req_len = 0;
    int unsigned req_strobes;

    // Idling knobs (tx_lazy, rx_lazy), changed only between phases, and idle counters
    logic        tx_lazy = 1'b0;
    logic        rx_lazy = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_hold = 0;

    int unsigned errors = 0;
    int unsigned requests_taken = 0;
    int unsigned ignored_codes = 0;
    int unsigned strobes_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned idle_cycles = 0;

    // ------------------------------------------------------------------
    // Strobe predictor
    // ------------------------------------------------------------------
    task automatic emit_strobe(input logic rs, input logic [7:0] pv,
                               input logic [4:0] pre, input logic [9:0] post);
        strobe_t s;
        s.rs       = rs;
        s.port_val = pv;
        s.pre      = pre;
        // a zero pulse register still gives the shortest pulse
        s.pulse    = (pulse_tenths == 8'd0) ? 8'd1 : pulse_tenths;
        s.post     = post;
        s.fin      = 1'b0;
        expected_strobes.push_back(s);
        req_strobes++;
    endtask

    // One byte on the bus: a single strobe, or high nibble then low nibble
    // moved up. The pre-wait goes on the first nibble, the post-wait on the
    // second.
    task automatic emit_byte(input logic rs, input logic [7:0] b,
                             input logic [4:0] pre, input logic [9:0] post);
        logic [7:0] lo;
        lo = b << 4;
        if (bus_is_four)
        begin
            emit_strobe(rs, b & 8'hF0, pre, POST_SHORT);
            emit_strobe(rs, lo, PRE_NONE, post);
        end
        else
        begin
            emit_strobe(rs, b, pre, post);
        end
    endtask

    task automatic expand_request(input request_t rq);
        logic [2:0] li;
        logic [7:0] addr;
        logic [7:0] num;
        logic [7:0] tens;
        logic [7:0] ones;
        req_strobes = 0;
        case (rq.code)
            FUNC_INIT:
            begin
                if (bus_is_four)
                begin
                    emit_byte(1'b0, 8'h33, PRE_NONE, POST_SHORT);
                    emit_byte(1'b0, 8'h32, PRE_NONE, POST_SHORT);
                    emit_byte(1'b0, 8'h28, PRE_NONE, POST_SHORT);
                end
                else
                begin
                    emit_byte(1'b0, 8'h38, PRE_LONG, POST_SHORT);
                end
                emit_byte(1'b0, 8'h0E, PRE_NONE, POST_SHORT);
                emit_byte(1'b0, 8'h01, PRE_NONE, POST_SHORT);
                emit_byte(1'b0, 8'h06, PRE_LONG, POST_SHORT);
            end
            FUNC_CMD:  emit_byte(1'b0, rq.arg, PRE_NONE, POST_SHORT);
            FUNC_DATA: emit_byte(1'b1, rq.arg, PRE_NONE, POST_SHORT);
            FUNC_CURSOR:
            begin
                // lines outside 1..4 fold onto the two low bits, address wraps
                li   = rq.line_no - 3'd1;
                addr = LINE_STARTS[li[1:0]*8 +: 8] + {3'b000, rq.col_no} - 8'd1;
                emit_byte(1'b0, addr, PRE_NONE, POST_HOME);
            end
            FUNC_DIGIT: emit_byte(1'b1, rq.arg + CHAR_ZERO, PRE_NONE, POST_SHORT);
            FUNC_NUMBER:
            begin
                num  = (rq.arg > 8'd99) ? 8'd99 : rq.arg;
                tens = num / 8'd10 + CHAR_ZERO;
                ones = num % 8'd10 + CHAR_ZERO;
                emit_byte(1'b1, tens, PRE_NONE, POST_SHORT);
                emit_byte(1'b1, ones, PRE_NONE, POST_SHORT);
            end
            default:
            begin
                ignored_codes++;
                return;
            end
        endcase
        expected_strobes[expected_strobes.size()-1].fin = 1'b1;
        last_req_code = rq.code;
        last_req_len  = req_strobes;
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    task automatic present(input request_t rq);
        func     <= rq.code;
        value    <= rq.arg;
        row      <= rq.line_no;
        column   <= rq.col_no;
        in_valid <= 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        request_t    rq;
        int unsigned n;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            // transfer done: predict from the payload that was just taken
            rq.code    = func;
            rq.arg     = value;
            rq.line_no = row;
            rq.col_no  = column;
            expand_request(rq);
            requests_taken++;
            n = tx_lazy ? $urandom_range(0, 3) : 0;
            if (n == 0 && pending_requests.size() != 0)
            begin
                present(pending_requests.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
                tx_gap   <= n;
            end
        end
        else if (!in_valid)
        begin
            if (tx_gap != 0)
                tx_gap <= tx_gap - 1;
            else if (pending_requests.size() != 0)
                present(pending_requests.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // Strobe monitor and checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: strobe %0d %s mismatch: expected %0d, actual %0d",
                     $time, strobes_checked, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : strobe_monitor
        strobe_t     want;
        int unsigned n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_hold   <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (expected_strobes.size() == 0)
            begin
                $display("%0t: unexpected strobe: expected none, actual byte %h rs %b",
                         $time, port_byte, reg_select);
                errors++;
            end
            else
            begin
                want = expected_strobes.pop_front();
                check_field("reg_select", want.rs, reg_select);
                check_field("port_byte", want.port_val, port_byte);
                check_field("wait_before", want.pre, wait_before);
                check_field("strobe_high", want.pulse, strobe_high);
                check_field("wait_after", want.post, wait_after);
                check_field("last", want.fin, last);
            end
            strobes_checked++;
            // hold off the next strobe for a random number of cycles
            n = rx_lazy ? $urandom_range(0, 3) : 0;
            rx_hold   <= n;
            out_stall <= (n != 0);
        end
        else if (out_stall)
        begin
            if (rx_hold <= 1)
                out_stall <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
    end

    // ------------------------------------------------------------------
    // Hang watchdog: any transfer on any channel restarts the count
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == HANG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [2:0] code, input logic [7:0] arg,
                             input logic [2:0] line_no, input logic [4:0] col_no);
        request_t rq;
        rq.code    = code;
        rq.arg     = arg;
        rq.line_no = line_no;
        rq.col_no  = col_no;
        pending_requests.push_back(rq);
    endtask

    // Sender holds off until every predicted strobe is out and the block
    // has had time to finish anything that makes no strobe. Sampled on the
    // falling edge so the driver's and monitor's updates have landed.
    task automatic settle();
        while (pending_requests.size() != 0 || in_valid || expected_strobes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FOUR_BIT_BUS)
            bus_is_four = data[0];
        else
            pulse_tenths = data;
        reg_writes++;
    endtask

    // Mostly well-formed requests; a few spare codes and out-of-range
    // lines and columns mixed in.
    function automatic request_t random_request();
        request_t rq;
        if ($urandom_range(0, 99) < 6)
            rq.code = 3'($urandom_range(6, 7));
        else
            rq.code = 3'($urandom_range(0, 5));
        case ($urandom_range(0, 3))
            0:       rq.arg = 8'($urandom_range(0, 9));
            1:       rq.arg = 8'($urandom_range(0, 99));
            default: rq.arg = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 9) < 8)
            rq.line_no = 3'($urandom_range(1, 4));
        else
            rq.line_no = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 8)
            rq.col_no = 5'($urandom_range(1, 20));
        else
            rq.col_no = 5'($urandom_range(0, 31));
        return rq;
    endfunction

    // Queue a batch with the given number of real requests; spare codes
    // ride along without counting.
    task automatic run_random(input int unsigned count);
        request_t    rq;
        int unsigned real_reqs;
        real_reqs = 0;
        tx_lazy = ($urandom_range(0, 3) != 0);
        rx_lazy = ($urandom_range(0, 3) != 0);
        while (real_reqs < count)
        begin
            rq = random_request();
            pending_requests.push_back(rq);
            if (rq.code <= FUNC_NUMBER)
                real_reqs++;
        end
        settle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 8-bit bus, pulse 10. Directed corners, idling on
        // both sides.
        tx_lazy = 1'b1;
        rx_lazy = 1'b1;
        queue_req(FUNC_INIT, 8'h00, 3'd1, 5'd1);
        queue_req(FUNC_CMD, 8'h00, 3'd1, 5'd1);
        queue_req(FUNC_CMD, 8'hFF, 3'd1, 5'd1);
        queue_req(FUNC_DATA, 8'h41, 3'd1, 5'd1);
        queue_req(FUNC_DATA, 8'hFF, 3'd1, 5'd1);
        queue_req(FUNC_CURSOR, 8'h00, 3'd1, 5'd1);
        queue_req(FUNC_CURSOR, 8'h00, 3'd4, 5'd20);
        // line 0 folds to line 4, column 0 steps back one address
        queue_req(FUNC_CURSOR, 8'h00, 3'd0, 5'd0);
        queue_req(FUNC_CURSOR, 8'hFF, 3'd7, 5'd31);
        queue_req(FUNC_DIGIT, 8'd0, 3'd1, 5'd1);
        queue_req(FUNC_DIGIT, 8'd9, 3'd1, 5'd1);
        // character code wraps past 255
        queue_req(FUNC_DIGIT, 8'd255, 3'd1, 5'd1);
        queue_req(FUNC_NUMBER, 8'd0, 3'd1, 5'd1);
        queue_req(FUNC_NUMBER, 8'd99, 3'd1, 5'd1);
        // saturates at 99
        queue_req(FUNC_NUMBER, 8'd255, 3'd1, 5'd1);
        queue_req(FUNC_SPARE_6, 8'hAA, 3'd5, 5'd10);
        queue_req(FUNC_SPARE_7, 8'h55, 3'd2, 5'd21);
        settle();

        // 4-bit bus, longest pulse, no idling at all
        write_reg(CFG_FOUR_BIT_BUS, 8'd1);
        write_reg(CFG_STROBE_HIGH, 8'd255);
        tx_lazy = 1'b0;
        rx_lazy = 1'b0;
        queue_req(FUNC_INIT, 8'h00, 3'd1, 5'd1);
        queue_req(FUNC_CMD, 8'hA5, 3'd1, 5'd1);
        queue_req(FUNC_DATA, 8'h5A, 3'd1, 5'd1);
        queue_req(FUNC_CURSOR, 8'h00, 3'd3, 5'd12);
        queue_req(FUNC_DIGIT, 8'd7, 3'd1, 5'd1);
        queue_req(FUNC_NUMBER, 8'd47, 3'd1, 5'd1);
        queue_req(FUNC_NUMBER, 8'd100, 3'd1, 5'd1);
        settle();

        // pulse register zero still gives a one-tenth pulse
        write_reg(CFG_STROBE_HIGH, 8'd0);
        write_reg(CFG_FOUR_BIT_BUS, 8'd0);
        run_random(24);

        write_reg(CFG_FOUR_BIT_BUS, 8'd1);
        write_reg(CFG_STROBE_HIGH, 8'd1);
        run_random(24);

        write_reg(CFG_FOUR_BIT_BUS, 8'($urandom_range(0, 1)));
        write_reg(CFG_STROBE_HIGH, 8'($urandom_range(2, 254)));
        run_random(24);

        write_reg(CFG_FOUR_BIT_BUS, {7'd0, ~bus_is_four});
        write_reg(CFG_STROBE_HIGH, 8'd255);
        run_random(24);

        if (expected_strobes.size() != 0)
        begin
            $display("%0t: %0d strobes expected, actual none", $time,
                     expected_strobes.size());
            errors++;
        end
        $display("Took %0d requests (%0d spare codes), checked %0d strobes, %0d register writes",
                 requests_taken, ignored_codes, strobes_checked, reg_writes);
        $display("Both bus widths, pulse settings 0 to 255, random idling on both channels");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/lcdseq_pkg.sv
hw/rtl/lcdseq_sequencer.sv
hw/rtl/lcdseq_datapath.sv
hw/rtl/char_lcd_bus_sequencer_top.sv
tb/tb_top.sv
